@@ sv/klrl_pkg.sv @@
// shared types, constants and codes of the keyed log rate limiter
package klrl_pkg;

  // field widths
  localparam int unsigned KeyIdW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned LengthW  = 16;
  localparam int unsigned HoldoffW = 20;
  localparam int unsigned ReportW  = 16;
  localparam int unsigned OfflineW = 32;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 20;

  // default parameters
  localparam int unsigned GateCountDef = 8;
  localparam int unsigned KeyBitsDef   = 16;

  // register reset values
  localparam logic [LimitW-1:0]   LimitRst   = LimitW'(5);
  localparam logic [LengthW-1:0]  LengthRst  = LengthW'(1000);
  localparam logic [HoldoffW-1:0] HoldoffRst = HoldoffW'(10000);

  localparam logic [ReportW-1:0]  ReportMax  = '1;
  localparam logic [OfflineW-1:0] OfflineMax = '1;

  typedef enum logic [CfgAddrW-1:0] {
    REG_WINDOW_LIMIT  = 2'd0,
    REG_WINDOW_LENGTH = 2'd1,
    REG_HOLDOFF       = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  // search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [TimeW-1:0] hit_time;
  } tok_t;

  // slot update broadcast to the row
  typedef struct packed {
    logic             en;
    logic             set_key;
    logic [TimeW-1:0] next_time;
  } wr_t;

endpackage

@@ sv/klrl_gate_cell.sv @@
// one key gate slot: holds key and next allowed time, checks the passing search token
module klrl_gate_cell #(
  parameter int unsigned KEY_W  = klrl_pkg::KeyBitsDef,
  parameter int unsigned SLOT_W = 3,
  parameter int unsigned INDEX  = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [KEY_W-1:0]      key_i,
  input  klrl_pkg::tok_t        tok_i,
  input  logic [SLOT_W-1:0]     slot_i,
  output klrl_pkg::tok_t        tok_o,
  output logic [SLOT_W-1:0]     slot_o,
  input  klrl_pkg::wr_t         wr_i,
  input  logic [SLOT_W-1:0]     wr_slot_i
);

  logic                       valid_q;
  logic [KEY_W-1:0]           key_q;
  logic [klrl_pkg::TimeW-1:0] time_q;
  klrl_pkg::tok_t             tok_q, tok_d;
  logic [SLOT_W-1:0]          slot_q, slot_d;
  logic                       hit;
  logic                       wr_here;

  // first valid match along the row wins
  assign hit     = tok_i.valid && !tok_i.found && valid_q && (key_q == key_i);
  assign wr_here = wr_i.en && (wr_slot_i == SLOT_W'(INDEX));

  always_comb begin
    tok_d  = tok_i;
    slot_d = slot_i;
    if (hit) begin
      tok_d.found    = 1'b1;
      tok_d.hit_time = time_q;
      slot_d         = SLOT_W'(INDEX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_q     <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_here && wr_i.set_key) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (wr_here) begin
      time_q <= wr_i.next_time;
      if (wr_i.set_key) begin
        key_q <= key_i;
      end
    end
  end

  assign tok_o  = tok_q;
  assign slot_o = slot_q;

endmodule

@@ sv/keyed_log_rate_limiter.sv @@
// top level: request control, window counter and the row of key gate cells
//
//  channel  | dir | payload                                    | accepted when
//  s_axis   | in  | tdata key_id, now_ms; tuser link_up        | tvalid & tready
//  m_axis   | out | tdata suppressed_report, offline_drops;    | tvalid & tready
//           |     | tuser granted                              |
//  cfg      | in  | cfg_addr_i index, cfg_wdata_i value        | cfg_we_i
//
// one request at a time: a link-down request or a full window goes from the check state
// to the finish state and on into the output register; otherwise the search token walks
// the gate row, one cell a cycle, and the result is loaded once it leaves the last cell.
// the next accept can come in the cycle after the result is loaded into the output register.
// reset clears all gate slots, counters and the window; config returns to defaults.
// a stalled result waits in the output register while the next request is taken.
module keyed_log_rate_limiter #(
  parameter int unsigned GATE_COUNT = klrl_pkg::GateCountDef,
  parameter int unsigned KEY_BITS   = klrl_pkg::KeyBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: key_id [15:0], now_ms [47:16]
  input  logic [47:0]                   s_axis_tdata,
  // tuser: link_up
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: suppressed_report [15:0], offline_drops [47:16]
  output logic [47:0]                   m_axis_tdata,
  // tuser: granted
  output logic                          m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [klrl_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [klrl_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned SlotW = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
  localparam int unsigned KeyW  = (KEY_BITS < klrl_pkg::KeyIdW) ? KEY_BITS
                                                                : klrl_pkg::KeyIdW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(GATE_COUNT - 1);

  localparam int unsigned TW = klrl_pkg::TimeW;

  klrl_pkg::state_e state_q, state_d;

  logic [KeyW-1:0]               key_q, key_d;
  logic [TW-1:0]                 now_q, now_d;
  logic                          link_q, link_d;

  logic [klrl_pkg::LimitW-1:0]   limit_q, limit_d;
  logic [klrl_pkg::LengthW-1:0]  length_q, length_d;
  logic [klrl_pkg::HoldoffW-1:0] holdoff_q, holdoff_d;

  logic [TW-1:0]                 win_start_q, win_start_d;
  logic [klrl_pkg::LimitW-1:0]   win_count_q, win_count_d;
  logic [SlotW-1:0]              ptr_q, ptr_d;
  logic [klrl_pkg::ReportW-1:0]  supp_q, supp_d;
  logic [klrl_pkg::OfflineW-1:0] offl_q, offl_d;

  logic                          res_grant_q, res_grant_d;
  logic [klrl_pkg::ReportW-1:0]  res_report_q, res_report_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_grant_q, out_grant_d;
  logic [klrl_pkg::ReportW-1:0]  out_report_q, out_report_d;
  logic [klrl_pkg::OfflineW-1:0] out_offl_q, out_offl_d;

  klrl_pkg::tok_t                tok [GATE_COUNT+1];
  logic [SlotW-1:0]              slot [GATE_COUNT+1];
  klrl_pkg::wr_t                 wr;
  logic [SlotW-1:0]              wr_slot;
  klrl_pkg::tok_t                launch;

  logic [TW-1:0]                 win_diff;
  logic [TW-1:0]                 gate_diff;
  logic [klrl_pkg::LimitW-1:0]   count_now;

  assign tok[0]  = launch;
  assign slot[0] = '0;

  for (genvar g = 0; g < GATE_COUNT; g++) begin : g_cell
    klrl_gate_cell #(
      .KEY_W  (KeyW),
      .SLOT_W (SlotW),
      .INDEX  (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_i     (key_q),
      .tok_i     (tok[g]),
      .slot_i    (slot[g]),
      .tok_o     (tok[g+1]),
      .slot_o    (slot[g+1]),
      .wr_i      (wr),
      .wr_slot_i (wr_slot)
    );
  end

  assign win_diff  = now_q - win_start_q;
  assign gate_diff = now_q - tok[GATE_COUNT].hit_time;

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    now_d        = now_q;
    link_d       = link_q;
    limit_d      = limit_q;
    length_d     = length_q;
    holdoff_d    = holdoff_q;
    win_start_d  = win_start_q;
    win_count_d  = win_count_q;
    ptr_d        = ptr_q;
    supp_d       = supp_q;
    offl_d       = offl_q;
    res_grant_d  = res_grant_q;
    res_report_d = res_report_q;
    out_valid_d  = out_valid_q;
    out_grant_d  = out_grant_q;
    out_report_d = out_report_q;
    out_offl_d   = out_offl_q;
    launch       = '0;
    wr           = '0;
    wr_slot      = ptr_q;
    count_now    = win_count_q;

    s_axis_tready = (state_q == klrl_pkg::ST_IDLE);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_addr_i)
        klrl_pkg::REG_WINDOW_LIMIT:  limit_d   = cfg_wdata_i[klrl_pkg::LimitW-1:0];
        klrl_pkg::REG_WINDOW_LENGTH: length_d  = cfg_wdata_i[klrl_pkg::LengthW-1:0];
        klrl_pkg::REG_HOLDOFF:       holdoff_d = cfg_wdata_i[klrl_pkg::HoldoffW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      klrl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          key_d   = s_axis_tdata[KeyW-1:0];
          now_d   = s_axis_tdata[47:16];
          link_d  = s_axis_tuser;
          state_d = klrl_pkg::ST_CHECK;
        end
      end

      klrl_pkg::ST_CHECK: begin
        res_grant_d  = 1'b0;
        res_report_d = '0;
        if (!link_q) begin
          if (offl_q != klrl_pkg::OfflineMax) begin
            offl_d = offl_q + 1'b1;
          end
          state_d = klrl_pkg::ST_FINISH;
        end else begin
          // window rolls when the signed distance reaches the window length
          if (!win_diff[TW-1] && (win_diff >= TW'(length_q))) begin
            win_start_d = now_q;
            count_now   = '0;
          end
          win_count_d = count_now;
          if (count_now >= limit_q) begin
            if (supp_q != klrl_pkg::ReportMax) begin
              supp_d = supp_q + 1'b1;
            end
            state_d = klrl_pkg::ST_FINISH;
          end else begin
            launch.valid = 1'b1;
            state_d      = klrl_pkg::ST_SEARCH;
          end
        end
      end

      klrl_pkg::ST_SEARCH: begin
        if (tok[GATE_COUNT].valid) begin
          state_d = klrl_pkg::ST_FINISH;
          if (tok[GATE_COUNT].found && gate_diff[TW-1]) begin
            // key still in hold-off
            res_grant_d  = 1'b0;
            res_report_d = '0;
            if (supp_q != klrl_pkg::ReportMax) begin
              supp_d = supp_q + 1'b1;
            end
          end else begin
            wr.en        = 1'b1;
            wr.set_key   = !tok[GATE_COUNT].found;
            wr.next_time = now_q + TW'(holdoff_q);
            if (tok[GATE_COUNT].found) begin
              wr_slot = slot[GATE_COUNT];
            end else begin
              ptr_d = (ptr_q == LastSlot) ? '0 : ptr_q + 1'b1;
            end
            win_count_d  = win_count_q + 1'b1;
            res_grant_d  = 1'b1;
            res_report_d = supp_q;
            supp_d       = '0;
          end
        end
      end

      klrl_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_grant_d  = res_grant_q;
          out_report_d = res_report_q;
          out_offl_d   = offl_q;
          state_d      = klrl_pkg::ST_IDLE;
        end
      end

      default: state_d = klrl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= klrl_pkg::ST_IDLE;
      limit_q     <= klrl_pkg::LimitRst;
      length_q    <= klrl_pkg::LengthRst;
      holdoff_q   <= klrl_pkg::HoldoffRst;
      win_start_q <= '0;
      win_count_q <= '0;
      ptr_q       <= '0;
      supp_q      <= '0;
      offl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      length_q    <= length_d;
      holdoff_q   <= holdoff_d;
      win_start_q <= win_start_d;
      win_count_q <= win_count_d;
      ptr_q       <= ptr_d;
      supp_q      <= supp_d;
      offl_q      <= offl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    now_q        <= now_d;
    link_q       <= link_d;
    res_grant_q  <= res_grant_d;
    res_report_q <= res_report_d;
    out_grant_q  <= out_grant_d;
    out_report_q <= out_report_d;
    out_offl_q   <= out_offl_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_grant_q;
  assign m_axis_tdata  = {out_offl_q, out_report_q};

endmodule
